// ===== hdl/pdt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PD turn controller package
// Widths, codes, fixed-point constants and saturation helpers shared by the
// turn controller.
// ----------------------------------------------------------------------------
package pdt_pkg;

	// angle word width (heading, target, error); legal range 24..48
	localparam int ANGLE_BITS = 32;

	localparam int REQ_W     = 23;
	localparam int HDG_W     = 32;
	localparam int GAIN_W    = 16;
	localparam int MAG_W     = 17;
	localparam int TOL_W     = 16;
	localparam int CNT_W     = 6;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int DRV_OUT_W = 18;
	localparam int STATUS_W  = 3;

	// pipeline depth from input register to last compute stage
	localparam int NSTG = 8;

	// item kinds
	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DRIVE     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SMALL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ON_TARGET = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_D_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_DRIVE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_THR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_TOL     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CORR_LIMIT  = 3'd6;

	// register reset values
	localparam logic [GAIN_W-1:0] RST_P_GAIN      = 16'd1792;
	localparam logic [GAIN_W-1:0] RST_D_GAIN      = 16'd1792;
	localparam logic [MAG_W-1:0]  RST_DRIVE_LIMIT = 17'd65000;
	localparam logic [MAG_W-1:0]  RST_SMALL_DRIVE = 17'd30000;
	localparam logic [MAG_W-1:0]  RST_SMALL_THR   = 17'd7000;
	localparam logic [TOL_W-1:0]  RST_ERR_TOL     = 16'd10;
	localparam logic [CNT_W-1:0]  RST_CORR_LIMIT  = 6'd50;

	// turn compensation: round(|a| * coef / 1000) then an offset
	localparam int COEF_W       = 11;
	localparam int COEF_POS     = 987;
	localparam int COEF_NEG     = 1030;
	localparam int COMP_RND     = 500;
	localparam int COMP_POS_OFS = 2000;
	localparam int COMP_NEG_OFS = 1230;
	localparam int COMP_X_W     = REQ_W + COEF_W - 1;
	// x / 1000 == (x >> 3) / 125; the /125 is a multiply by ceil(2^37 / 125)
	localparam int COMP_PRE_SH  = 3;
	localparam int COMP_Y_W     = COMP_X_W - COMP_PRE_SH;
	localparam int RECIP_W      = 31;
	localparam logic [RECIP_W-1:0] RECIP_M = 31'd1099511628;
	localparam int PROD_C_W     = COMP_Y_W + RECIP_W;
	localparam int COMP_Q_W     = 24;

	// angle arithmetic runs in a word wide enough for any sum of two angles
	localparam int WIDE_W = ((ANGLE_BITS > HDG_W) ? ANGLE_BITS : HDG_W) + 2;
	localparam logic signed [WIDE_W-1:0] ANG_HI =
		{{(WIDE_W-ANGLE_BITS+1){1'b0}}, {(ANGLE_BITS-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] ANG_LO = ~ANG_HI;

	// PD sum: gain (unsigned Q8.8) times angle, two terms, saturate to 64 bits
	localparam int PROD_W    = ANGLE_BITS + GAIN_W + 1;
	localparam int SUM_W     = PROD_W + 1;
	localparam int SUMX_W    = (SUM_W > 65) ? SUM_W : 65;
	localparam int SAT_W     = (SUM_W < 64) ? SUM_W : 64;
	localparam int DRV_SHIFT = 8;
	localparam int DRV_W     = SAT_W - DRV_SHIFT;
	localparam logic signed [SUMX_W-1:0] SUM_HI = {{(SUMX_W-63){1'b0}}, {63{1'b1}}};
	localparam logic signed [SUMX_W-1:0] SUM_LO = -SUM_HI;

	function automatic logic signed [WIDE_W-1:0] ang_ext(
		input logic signed [ANGLE_BITS-1:0] a
	);
		return {{(WIDE_W-ANGLE_BITS){a[ANGLE_BITS-1]}}, a};
	endfunction

	function automatic logic signed [WIDE_W-1:0] hdg_ext(
		input logic signed [HDG_W-1:0] h
	);
		return {{(WIDE_W-HDG_W){h[HDG_W-1]}}, h};
	endfunction

	function automatic logic signed [ANGLE_BITS-1:0] sat_angle(
		input logic signed [WIDE_W-1:0] x
	);
		logic signed [WIDE_W-1:0] r;
		if (x > ANG_HI) begin
			r = ANG_HI;
		end else if (x < ANG_LO) begin
			r = ANG_LO;
		end else begin
			r = x;
		end
		return r[ANGLE_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/pd_turn_controller_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PD turn controller
// Heading controller: compensates a requested turn, tracks heading error and
// issues a clamped PD drive or small end-of-turn corrections.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one item per turn start or gyro
//    sample. A start item (action 0) sets a new target from requested_turn and
//    measured_heading; a sample item (action 1) updates the heading error.
//  - Output channel (out_valid / out_stall): exactly one result item per
//    input item, in order: drive_level, status and turn_done.
//  - Throughput: one item per clock while the output is not stalled; the block
//    is a nine-register pipeline (input register, seven compute stages, output
//    register) and each stage holds one item.
//  - Path: an accepted item passes the compensation multiply-by-reciprocal,
//    the two gain multipliers and the 64-bit saturating sum, each closed by a
//    register, before it reaches out_valid.
//  - Stall: a stalled result holds in the output register; earlier stages
//    keep filling bubbles, and in_stall rises only when every stage is full.
//  - Configuration: cfg_wr_en with cfg_index / cfg_wdata writes one register
//    per edge; write only while no item is in flight. Unknown indexes drop.
//  - Reset (arst_n low): pipeline empties, registers take their defaults and
//    the controller is idle, so samples report status idle until a start.
// ----------------------------------------------------------------------------
module pd_turn_controller_top (
	input  wire                                        clk,
	input  wire                                        arst_n,
	// configuration write port
	input  wire                                        cfg_wr_en,
	input  wire  [pdt_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  wire  [pdt_pkg::CFG_W-1:0]                  cfg_wdata,
	// input item channel
	input  wire                                        in_valid,
	output logic                                       in_stall,
	input  wire                                        action,
	input  wire  signed [pdt_pkg::REQ_W-1:0]           requested_turn,
	input  wire  signed [pdt_pkg::HDG_W-1:0]           measured_heading,
	// result item channel
	output logic                                       out_valid,
	input  wire                                        out_stall,
	output logic signed [pdt_pkg::DRV_OUT_W-1:0]       drive_level,
	output logic [pdt_pkg::STATUS_W-1:0]               status,
	output logic                                       turn_done
);
	import pdt_pkg::*;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [GAIN_W-1:0] p_gain_q, d_gain_q;
	logic [MAG_W-1:0]  drive_limit_q, small_drive_q, small_thr_q;
	logic [TOL_W-1:0]  err_tol_q;
	logic [CNT_W-1:0]  corr_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q      <= RST_P_GAIN;
			d_gain_q      <= RST_D_GAIN;
			drive_limit_q <= RST_DRIVE_LIMIT;
			small_drive_q <= RST_SMALL_DRIVE;
			small_thr_q   <= RST_SMALL_THR;
			err_tol_q     <= RST_ERR_TOL;
			corr_limit_q  <= RST_CORR_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_P_GAIN:      p_gain_q      <= cfg_wdata[GAIN_W-1:0];
				REG_D_GAIN:      d_gain_q      <= cfg_wdata[GAIN_W-1:0];
				REG_DRIVE_LIMIT: drive_limit_q <= cfg_wdata[MAG_W-1:0];
				REG_SMALL_DRIVE: small_drive_q <= cfg_wdata[MAG_W-1:0];
				REG_SMALL_THR:   small_thr_q   <= cfg_wdata[MAG_W-1:0];
				REG_ERR_TOL:     err_tol_q     <= cfg_wdata[TOL_W-1:0];
				REG_CORR_LIMIT:  corr_limit_q  <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline flow control
	// A stage takes a new item when it is empty or its item moves on.
	// Walk the take chain back from the output register.
	// ------------------------------------------------------------------
	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] take;
	logic [NSTG:1]   adv;
	logic            out_valid_q;
	logic            in_fire;

	always_comb begin
		take[NSTG+1] = !out_valid_q || !out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			take[k] = !vld_q[k] || take[k+1];
		end
	end

	assign adv      = vld_q & take[NSTG+1:2];
	assign in_stall = !take[1];
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take[1]) begin
				vld_q[1] <= in_fire;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (take[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (take[NSTG+1]) begin
				out_valid_q <= vld_q[NSTG];
			end
		end
	end

	// ------------------------------------------------------------------
	// stage payload registers
	// ------------------------------------------------------------------
	logic                          act_s1, act_s2, act_s3, act_s4;
	logic                          act_s5, act_s6, act_s7, act_s8;
	logic signed [REQ_W-1:0]       req_s1;
	logic signed [HDG_W-1:0]       hdg_s1;
	logic                          neg_s2, neg_s3;
	logic [COMP_X_W-1:0]           x_s2;
	logic signed [ANGLE_BITS-1:0]  hdg_s2, hdg_s3, hdg_s4;
	logic [COMP_Q_W-1:0]           q_s3;
	logic signed [ANGLE_BITS-1:0]  tgt_s4;
	logic signed [ANGLE_BITS-1:0]  err_s5, prev_s5;
	logic signed [ANGLE_BITS-1:0]  err_s6, diff_s6;
	logic                          ontgt_s6, ontgt_s7, ontgt_s8;
	logic signed [PROD_W-1:0]      mp_s7, md_s7;
	logic signed [DRV_W-1:0]       drive_s8;
	logic                          pos_s8;

	// stage 1: compensation product, rounded, and heading saturation
	logic                          neg1;
	logic [REQ_W-1:0]              mag1;
	logic [COEF_W-1:0]             coef1;
	logic [COMP_X_W-1:0]           x1;
	logic signed [ANGLE_BITS-1:0]  hdg1;

	always_comb begin
		neg1  = req_s1[REQ_W-1];
		mag1  = neg1 ? REQ_W'(-req_s1) : REQ_W'(req_s1);
		coef1 = neg1 ? COEF_W'(COEF_NEG) : COEF_W'(COEF_POS);
		x1    = COMP_X_W'(mag1) * COMP_X_W'(coef1) + COMP_X_W'(COMP_RND);
		hdg1  = sat_angle(hdg_ext(hdg_s1));
	end

	// stage 2: divide by 1000 through the reciprocal multiply
	logic [COMP_Y_W-1:0]           y2;
	logic [PROD_C_W-1:0]           pc2;
	logic [COMP_Q_W-1:0]           q2;

	always_comb begin
		y2  = x_s2[COMP_X_W-1:COMP_PRE_SH];
		pc2 = PROD_C_W'(y2) * PROD_C_W'(RECIP_M);
		q2  = pc2[PROD_C_W-1 -: COMP_Q_W];
	end

	// stage 3: apply offset, form the target a start would set
	logic signed [WIDE_W-1:0]      qx3, angle3;
	logic signed [ANGLE_BITS-1:0]  tgt3;

	always_comb begin
		qx3    = {{(WIDE_W-COMP_Q_W){1'b0}}, q_s3};
		angle3 = neg_s3 ? (-qx3 - WIDE_W'(COMP_NEG_OFS)) : (qx3 - WIDE_W'(COMP_POS_OFS));
		tgt3   = sat_angle(ang_ext(hdg_s3) + angle3);
	end

	// stage 4: target and error state. Samples update the error even when the
	// controller is idle; a start overwrites it and zeroes the previous error,
	// so nothing stale reaches a later result.
	logic signed [ANGLE_BITS-1:0]  target_q, heading_err_q;
	logic signed [ANGLE_BITS-1:0]  base4, err4, prev4;

	always_comb begin
		base4 = (act_s4 == ACT_START) ? tgt_s4 : target_q;
		err4  = sat_angle(ang_ext(base4) - ang_ext(hdg_s4));
		prev4 = (act_s4 == ACT_START) ? '0 : heading_err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q      <= '0;
			heading_err_q <= '0;
		end else if (adv[4]) begin
			if (act_s4 == ACT_START) begin
				target_q <= tgt_s4;
			end
			heading_err_q <= err4;
		end
	end

	// stage 5: error difference and on-target check
	logic signed [ANGLE_BITS-1:0]  diff5;
	logic [ANGLE_BITS-1:0]         abs_err5;
	logic                          ontgt5;

	always_comb begin
		diff5    = sat_angle(ang_ext(err_s5) - ang_ext(prev_s5));
		abs_err5 = err_s5[ANGLE_BITS-1] ? (~err_s5 + 1'b1) : err_s5;
		ontgt5   = abs_err5 <= ANGLE_BITS'(err_tol_q);
	end

	// stage 6: gain multipliers
	logic signed [PROD_W-1:0]      mp6, md6;

	always_comb begin
		mp6 = $signed({1'b0, p_gain_q}) * err_s6;
		md6 = $signed({1'b0, d_gain_q}) * diff_s6;
	end

	// stage 7: saturating sum, floor divide by the Q8.8 scale
	logic signed [SUMX_W-1:0]      sum7, sat7;
	logic                          pos7;
	logic signed [DRV_W-1:0]       drive7;

	always_comb begin
		sum7 = {{(SUMX_W-PROD_W){mp_s7[PROD_W-1]}}, mp_s7}
		     + {{(SUMX_W-PROD_W){md_s7[PROD_W-1]}}, md_s7};
		if (sum7 > SUM_HI) begin
			sat7 = SUM_HI;
		end else if (sum7 < SUM_LO) begin
			sat7 = SUM_LO;
		end else begin
			sat7 = sum7;
		end
		pos7   = !sum7[SUMX_W-1] && (sum7 != '0);
		drive7 = sat7[SAT_W-1:DRV_SHIFT];
	end

	// stage 8: turn state, small corrections and clamp
	logic                          turning_q;
	logic [CNT_W-1:0]              corr_cnt_q;
	logic                          turn_cur8, turn_n8;
	logic [CNT_W-1:0]              cnt_cur8, cnt_n8;
	logic [DRV_W-1:0]              abs_drv8;
	logic signed [DRV_W-1:0]       lim8, clamp8;
	logic                          small8;
	logic signed [DRV_OUT_W-1:0]   sd8, drv_o8;
	logic [STATUS_W-1:0]           st_o8;
	logic                          done_o8;

	always_comb begin
		turn_cur8 = (act_s8 == ACT_START) ? 1'b1 : turning_q;
		cnt_cur8  = (act_s8 == ACT_START) ? '0 : corr_cnt_q;
		abs_drv8  = drive_s8[DRV_W-1] ? (~drive_s8 + 1'b1) : drive_s8;
		small8    = abs_drv8 < DRV_W'(small_thr_q);
		lim8      = {{(DRV_W-MAG_W){1'b0}}, drive_limit_q};
		if (drive_s8 > lim8) begin
			clamp8 = lim8;
		end else if (drive_s8 < -lim8) begin
			clamp8 = -lim8;
		end else begin
			clamp8 = drive_s8;
		end
		sd8 = {1'b0, small_drive_q};

		turn_n8 = turn_cur8;
		cnt_n8  = cnt_cur8;
		drv_o8  = '0;
		st_o8   = ST_IDLE;
		done_o8 = 1'b0;
		if (!turn_cur8) begin
			st_o8 = ST_IDLE;
		end else if (ontgt_s8) begin
			st_o8   = ST_ON_TARGET;
			done_o8 = 1'b1;
			turn_n8 = 1'b0;
		end else if (small8) begin
			if (cnt_cur8 < corr_limit_q) begin
				cnt_n8 = cnt_cur8 + 1'b1;
				drv_o8 = pos_s8 ? sd8 : -sd8;
				st_o8  = ST_SMALL;
			end else begin
				st_o8   = ST_EXHAUSTED;
				done_o8 = 1'b1;
				turn_n8 = 1'b0;
			end
		end else begin
			drv_o8 = clamp8[DRV_OUT_W-1:0];
			st_o8  = ST_DRIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turning_q  <= 1'b0;
			corr_cnt_q <= '0;
		end else if (adv[NSTG]) begin
			turning_q  <= turn_n8;
			corr_cnt_q <= cnt_n8;
		end
	end

	// output register payload
	logic signed [DRV_OUT_W-1:0]   drive_q;
	logic [STATUS_W-1:0]           status_q;
	logic                          done_q;

	// advance payload with each stage's take; bubbles carry don't-care data
	always_ff @(posedge clk) begin
		if (take[1]) begin
			act_s1 <= action;
			req_s1 <= requested_turn;
			hdg_s1 <= measured_heading;
		end
		if (take[2]) begin
			act_s2 <= act_s1;
			neg_s2 <= neg1;
			x_s2   <= x1;
			hdg_s2 <= hdg1;
		end
		if (take[3]) begin
			act_s3 <= act_s2;
			neg_s3 <= neg_s2;
			q_s3   <= q2;
			hdg_s3 <= hdg_s2;
		end
		if (take[4]) begin
			act_s4 <= act_s3;
			tgt_s4 <= tgt3;
			hdg_s4 <= hdg_s3;
		end
		if (take[5]) begin
			act_s5  <= act_s4;
			err_s5  <= err4;
			prev_s5 <= prev4;
		end
		if (take[6]) begin
			act_s6   <= act_s5;
			err_s6   <= err_s5;
			diff_s6  <= diff5;
			ontgt_s6 <= ontgt5;
		end
		if (take[7]) begin
			act_s7   <= act_s6;
			mp_s7    <= mp6;
			md_s7    <= md6;
			ontgt_s7 <= ontgt_s6;
		end
		if (take[8]) begin
			act_s8   <= act_s7;
			drive_s8 <= drive7;
			pos_s8   <= pos7;
			ontgt_s8 <= ontgt_s7;
		end
		if (take[NSTG+1]) begin
			drive_q  <= drv_o8;
			status_q <= st_o8;
			done_q   <= done_o8;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_level = drive_q;
	assign status      = status_q;
	assign turn_done   = done_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> (status_q == ST_ON_TARGET) || (status_q == ST_EXHAUSTED))
		else $error("turn ended with a status that does not end a turn");

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_IDLE) |-> (drive_q == '0) && !done_q)
		else $error("idle result carries drive or done");

	a_turn_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(turning_q) |-> out_valid_q && done_q)
		else $error("controller went idle without a done result");

	a_small_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_SMALL) |->
			(drive_q == $signed({1'b0, small_drive_q})) ||
			(drive_q == -$signed({1'b0, small_drive_q})))
		else $error("small correction magnitude mismatch");

endmodule
`default_nettype wire
